// File: hdl/css_pkg.sv
// shared types and character constants for the comment and string stripper
// no dependencies; imported by the scan core, the result buffer and the top level
`default_nettype none

package css_pkg;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_NL     = 8'h0A;

	// results one input item can cause, and the width of a count of them
	localparam int MAX_RES = 6;
	localparam int RES_W   = 3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       stream_end;
	} res_t;

	// all results of one item, handed from the scan core to the result buffer
	typedef struct packed {
		logic [RES_W-1:0]   count;
		res_t [MAX_RES-1:0] slot;
	} batch_t;

	function automatic res_t data_res(input logic [7:0] b);
		res_t r;
		r.out_byte   = b;
		r.byte_valid = 1'b1;
		r.run_last   = 1'b0;
		r.stream_end = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/css_if.sv
// valid/ready channel interfaces for text items and stripped result items
// depends on nothing but the handshake wires declared here
`default_nettype none

interface css_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface css_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       stream_end;

	modport source (output valid, output out_byte, output byte_valid, output run_last,
		output stream_end, input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input run_last,
		input stream_end, output ready);
endinterface

`default_nettype wire

// File: hdl/css_scan.sv
// scan core: mode and lookahead state plus the single-pass step over the byte window
// depends on css_pkg
`default_nettype none

module css_scan
	import css_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       process,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output batch_t          batch
);

	localparam logic [2:0] MODE_NORMAL     = 3'd0;
	localparam logic [2:0] MODE_LINE       = 3'd1;
	localparam logic [2:0] MODE_BLOCK      = 3'd2;
	localparam logic [2:0] MODE_BLOCK_STAR = 3'd3;
	localparam logic [2:0] MODE_STR        = 3'd4;
	localparam logic [2:0] MODE_STR_ESC    = 3'd5;

	logic [2:0] mode_q, mode_d;
	logic [1:0] cnt_q, cnt_d;
	logic [7:0] pend_q [3];
	logic [7:0] pend_d [3];

	logic [7:0] win [4];
	logic [2:0] k, pos, rem, need, pos1, posn;
	logic [7:0] c, b1, bn;
	logic       stop;
	logic [RES_W-1:0] n, idx;
	res_t [MAX_RES-1:0] res;
	logic [2:0] mode;

	always_comb begin
		// window: held bytes first, then the new byte
		win[0] = (cnt_q == 2'd0) ? in_byte : pend_q[0];
		win[1] = (cnt_q == 2'd1) ? in_byte : pend_q[1];
		win[2] = (cnt_q == 2'd2) ? in_byte : pend_q[2];
		win[3] = in_byte;
		k    = {1'b0, cnt_q} + 3'd1;
		mode = mode_q;
		pos  = 3'd0;
		stop = 1'b0;
		n    = '0;
		res  = '0;
		c    = '0;
		b1   = '0;
		bn   = '0;
		rem  = '0;
		need = '0;
		pos1 = '0;
		posn = '0;
		idx  = '0;
		// each pass consumes at least one byte, so four passes cover the window
		for (int s = 0; s < 4; s++) begin
			if (!stop && pos < k) begin
				c    = win[pos[1:0]];
				rem  = k - pos;
				pos1 = pos + 3'd1;
				b1   = win[pos1[1:0]];
				unique case (mode)
					MODE_LINE: begin
						if (c == CH_NL) begin
							if (n < RES_W'(MAX_RES)) res[n] = data_res(CH_NL);
							n    = n + 1'b1;
							mode = MODE_NORMAL;
						end
						pos = pos + 3'd1;
					end
					MODE_BLOCK: begin
						if (c == CH_STAR) mode = MODE_BLOCK_STAR;
						pos = pos + 3'd1;
					end
					MODE_BLOCK_STAR: begin
						if (c == CH_SLASH) mode = MODE_NORMAL;
						else if (c != CH_STAR) mode = MODE_BLOCK;
						pos = pos + 3'd1;
					end
					MODE_STR: begin
						if (c == CH_BSLASH) begin
							mode = MODE_STR_ESC;
						end else if (c == CH_DQUOTE) begin
							if (n < RES_W'(MAX_RES)) res[n] = data_res(CH_DQUOTE);
							n    = n + 1'b1;
							mode = MODE_NORMAL;
						end
						pos = pos + 3'd1;
					end
					MODE_STR_ESC: begin
						mode = MODE_STR;
						pos  = pos + 3'd1;
					end
					default: begin
						// normal text, unused codes included
						mode = MODE_NORMAL;
						if (c == CH_SLASH) begin
							if (rem < 3'd2) begin
								if (!in_last) begin
									stop = 1'b1;
								end else begin
									if (n < RES_W'(MAX_RES)) res[n] = data_res(c);
									n   = n + 1'b1;
									pos = pos + 3'd1;
								end
							end else if (b1 == CH_SLASH) begin
								mode = MODE_LINE;
								pos  = pos + 3'd2;
							end else if (b1 == CH_STAR) begin
								mode = MODE_BLOCK;
								pos  = pos + 3'd2;
							end else begin
								if (n < RES_W'(MAX_RES)) res[n] = data_res(c);
								n   = n + 1'b1;
								pos = pos + 3'd1;
							end
						end else if (c == CH_SQUOTE) begin
							// escaped literal is four bytes, plain one three
							if (rem >= 3'd2) need = (b1 == CH_BSLASH) ? 3'd4 : 3'd3;
							else need = 3'd2;
							posn = pos + need - 3'd1;
							bn   = win[posn[1:0]];
							if (rem < need) begin
								if (!in_last) begin
									stop = 1'b1;
								end else begin
									if (n < RES_W'(MAX_RES)) res[n] = data_res(c);
									n   = n + 1'b1;
									pos = pos + 3'd1;
								end
							end else if (bn == CH_SQUOTE) begin
								if (n < RES_W'(MAX_RES)) res[n] = data_res(CH_SQUOTE);
								n = n + 1'b1;
								if (n < RES_W'(MAX_RES)) res[n] = data_res(CH_DASH);
								n = n + 1'b1;
								if (n < RES_W'(MAX_RES)) res[n] = data_res(CH_SQUOTE);
								n   = n + 1'b1;
								pos = pos + need;
							end else begin
								if (n < RES_W'(MAX_RES)) res[n] = data_res(c);
								n   = n + 1'b1;
								pos = pos + 3'd1;
							end
						end else if (c == CH_DQUOTE) begin
							if (n < RES_W'(MAX_RES)) res[n] = data_res(c);
							n    = n + 1'b1;
							mode = MODE_STR;
							pos  = pos + 3'd1;
						end else begin
							if (n < RES_W'(MAX_RES)) res[n] = data_res(c);
							n   = n + 1'b1;
							pos = pos + 3'd1;
						end
					end
				endcase
			end
		end

		// undecided bytes stay held for the next item
		cnt_d = 2'(k - pos);
		for (int j = 0; j < 3; j++) begin
			posn      = pos + 3'(j);
			pend_d[j] = win[posn[1:0]];
		end
		mode_d = mode;

		if (in_last) begin
			if (mode == MODE_LINE) begin
				if (n < RES_W'(MAX_RES)) res[n] = data_res(CH_NL);
				n = n + 1'b1;
			end else if (mode == MODE_STR || mode == MODE_STR_ESC) begin
				if (n < RES_W'(MAX_RES)) res[n] = data_res(CH_DQUOTE);
				n = n + 1'b1;
			end
			// bare end marker when the text ends with nothing to show
			if (n == '0) begin
				res[0] = '0;
				n      = RES_W'(1);
			end
			idx                 = n - 1'b1;
			res[idx].stream_end = 1'b1;
			mode_d              = MODE_NORMAL;
			cnt_d               = 2'd0;
		end
		if (n != '0) begin
			idx               = n - 1'b1;
			res[idx].run_last = 1'b1;
		end
		batch.count = n;
		batch.slot  = res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			cnt_q  <= 2'd0;
		end else if (process) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			for (int j = 0; j < 3; j++) pend_q[j] <= pend_d[j];
		end
	end

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		process && in_last |=> mode_q == MODE_NORMAL && cnt_q == 2'd0)
		else $error("state not cleared after final byte");
	a_hold_normal: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd0 |-> mode_q == MODE_NORMAL)
		else $error("lookahead held outside normal text");
`endif

endmodule

`default_nettype wire

// File: hdl/css_outbuf.sv
// result buffer: holds the results of one item and hands them out one per cycle while the output is ready
// depends on css_pkg and css_res_if
`default_nettype none

module css_outbuf
	import css_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  batch_t     batch,
	output logic       free,
	css_res_if.source  stripped
);

	res_t             slot_q [MAX_RES];
	logic [RES_W-1:0] cnt_q, idx_q;
	logic             pop;
	res_t             head;

	assign head           = slot_q[idx_q];
	assign stripped.valid = (idx_q != cnt_q);
	assign stripped.out_byte   = head.out_byte;
	assign stripped.byte_valid = head.byte_valid;
	assign stripped.run_last   = head.run_last;
	assign stripped.stream_end = head.stream_end;

	assign pop  = stripped.valid && stripped.ready;
	// free when empty or when the last held result leaves this cycle
	assign free = !stripped.valid || (pop && (idx_q + 1'b1 == cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load && batch.count != '0) begin
			cnt_q <= batch.count;
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && batch.count != '0) begin
			for (int i = 0; i < MAX_RES; i++) slot_q[i] <= batch.slot[i];
		end
	end

`ifndef SYNTHESIS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q && cnt_q <= RES_W'(MAX_RES))
		else $error("read index beyond held results");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("results loaded over undelivered ones");
`endif

endmodule

`default_nettype wire

// File: hdl/comment_string_stripper_unit.sv
// comment and string stripper, top level: input register, scan core, result buffer
// depends on css_pkg, css_if (css_text_if, css_res_if), css_scan and css_outbuf
// path: input register, scan once the buffer is free, results registered in the buffer
// throughput: one item per cycle while items cause at most one result and output is ready;
// an item causing several results holds the result buffer until its last result leaves
// reset: arst_n clears mode, held byte count and all valid flags; byte stores are not reset
`default_nettype none

module comment_string_stripper_unit
	import css_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	css_text_if.sink  text,
	css_res_if.source stripped
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic   free;
	logic   process;
	batch_t batch;

	// an item in the input register is scanned once the buffer can take its results
	assign process    = valid_s1 && free;
	// take a new item whenever the input register is empty or is moving on
	assign text.ready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.in_byte;
			last_s1 <= text.in_last;
		end
	end

	// mode tracking, lookahead hold and result packing for one item
	css_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.process (process),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.batch   (batch)
	);

	// holds the results of one item and drains them onto the output channel
	css_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (process),
		.batch    (batch),
		.free     (free),
		.stripped (stripped)
	);

`ifndef SYNTHESIS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !process |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("waiting item lost from input register");
`endif

endmodule

`default_nettype wire
